/* design/nlri_dec_pkg.sv */
// ----------------------------------------------------------------------------
// nlri_dec_pkg
// Shared types and constants of the NLRI prefix stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nlri_dec_pkg;

  // configuration register indexes
  localparam logic REG_ADDRESS_FAMILY = 1'b0;
  localparam logic REG_MAX_RECORDS    = 1'b1;

  // address family codes
  localparam logic [1:0] FAM_IPV4  = 2'd0;
  localparam logic [1:0] FAM_IPV6  = 2'd1;
  localparam logic [1:0] FAM_VPNV4 = 2'd2;

  localparam logic [12:0] MAX_RECORDS_RESET = 13'd4096;

  // prefix length limits in bits
  localparam logic [7:0] V4_MAX_BITS  = 8'd32;
  localparam logic [7:0] V6_MAX_BITS  = 8'd128;
  localparam logic [7:0] VPN_MIN_BITS = 8'd88;
  localparam logic [7:0] VPN_MAX_BITS = 8'd120;

  typedef enum logic [1:0] {
    KIND_RECORD  = 2'd0,
    KIND_DECODED = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_BODY   = 2'd1,
    PH_DROP   = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] upper;
    logic [63:0] lower;
    logic [7:0]  bits;
    logic [19:0] label;
    logic [15:0] asn;
    logic [31:0] value;
    logic [12:0] count;
    logic        fin;
  } res_t;

  // results caused by one item: an optional record, then an optional end result
  typedef struct packed {
    logic rec_v;
    logic tail_v;
    res_t rec;
    res_t tail;
  } bundle_t;

endpackage

`default_nettype wire

/* design/nlri_dec_core.sv */
// ----------------------------------------------------------------------------
// nlri_dec_core
// Input register, configuration registers and the per-byte decode state.
// ----------------------------------------------------------------------------
`default_nettype none

module nlri_dec_core (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire  [7:0]             s_byte,
  input  wire                    s_last,
  input  wire                    cfg_we,
  input  wire                    cfg_index,
  input  wire  [12:0]            cfg_data,
  input  wire                    slot_free,
  output logic                   push,
  output nlri_dec_pkg::bundle_t  bundle
);
  import nlri_dec_pkg::*;

  logic        address_family_hi, address_family_lo;
  logic [1:0]  address_family;
  logic [12:0] max_records;

  logic        in_v;
  logic [7:0]  in_byte;
  logic        in_last;

  phase_t      phase, phase_next;
  logic [4:0]  bytes_left, bytes_left_next;
  logic [7:0]  current_length, current_length_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [63:0] prefix_shift_upper, prefix_shift_upper_next;
  logic [63:0] prefix_shift_lower, prefix_shift_lower_next;
  logic [19:0] label_hold, label_hold_next;
  logic [15:0] asn_hold, asn_hold_next;
  logic [31:0] value_hold, value_hold_next;
  logic [12:0] record_count, record_count_next;
  logic [1:0]  rec_family, rec_family_next;

  logic        consume;
  // byte count of the body is bits 7:3; lengths that wrap here are rejected
  logic [7:0]  round_up;

  assign address_family = {address_family_hi, address_family_lo};
  assign consume  = in_v && (!(bundle.rec_v || bundle.tail_v) || slot_free);
  assign push     = consume;
  assign s_tready = !in_v || consume;
  assign round_up = in_byte + 8'd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_family_hi <= 1'b0;
      address_family_lo <= 1'b0;
      max_records       <= MAX_RECORDS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ADDRESS_FAMILY) begin
        {address_family_hi, address_family_lo} <= cfg_data[1:0];
      end else begin
        max_records <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_byte;
      in_last <= s_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LENGTH;
      bytes_left     <= '0;
      current_length <= '0;
      byte_position  <= '0;
      record_count   <= '0;
      rec_family     <= FAM_IPV4;
    end else if (consume) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      current_length <= current_length_next;
      byte_position  <= byte_position_next;
      record_count   <= record_count_next;
      rec_family     <= rec_family_next;
    end
    // holds are cleared at every length byte that passes the checks, before use
    if (consume) begin
      prefix_shift_upper <= prefix_shift_upper_next;
      prefix_shift_lower <= prefix_shift_lower_next;
      label_hold         <= label_hold_next;
      asn_hold           <= asn_hold_next;
      value_hold         <= value_hold_next;
    end
  end

  always_comb begin
    logic err;
    phase_next              = phase;
    bytes_left_next         = bytes_left;
    current_length_next     = current_length;
    byte_position_next      = byte_position;
    prefix_shift_upper_next = prefix_shift_upper;
    prefix_shift_lower_next = prefix_shift_lower;
    label_hold_next         = label_hold;
    asn_hold_next           = asn_hold;
    value_hold_next         = value_hold;
    record_count_next       = record_count;
    rec_family_next         = rec_family;
    bundle                  = '0;
    err                     = 1'b0;

    case (phase)
      PH_DROP: begin
        if (in_last) begin
          phase_next        = PH_LENGTH;
          record_count_next = '0;
        end
      end
      PH_LENGTH: begin
        rec_family_next = address_family;
        if (record_count >= max_records) begin
          err = 1'b1;
        end else begin
          case (address_family)
            FAM_IPV4:  err = in_byte > V4_MAX_BITS;
            FAM_IPV6:  err = in_byte > V6_MAX_BITS;
            FAM_VPNV4: err = (in_byte < VPN_MIN_BITS) || (in_byte > VPN_MAX_BITS);
            default:   err = 1'b1;
          endcase
        end
        if (!err) begin
          prefix_shift_upper_next = '0;
          prefix_shift_lower_next = '0;
          label_hold_next         = '0;
          asn_hold_next           = '0;
          value_hold_next         = '0;
          byte_position_next      = '0;
          current_length_next     = (address_family == FAM_VPNV4) ?
                                    in_byte - VPN_MIN_BITS : in_byte;
          bytes_left_next         = round_up[7:3];
          if (round_up[7:3] == 5'd0) begin
            record_count_next = record_count + 13'd1;
            bundle.rec_v      = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (rec_family == FAM_VPNV4) begin
          // label, two ignored RD type bytes, RD asn, RD value, prefix
          if (byte_position == 5'd0) label_hold_next[19:12] = in_byte;
          if (byte_position == 5'd1) label_hold_next[11:4]  = in_byte;
          if (byte_position == 5'd2) label_hold_next[3:0]   = in_byte[7:4];
          if (byte_position == 5'd5) asn_hold_next[15:8]    = in_byte;
          if (byte_position == 5'd6) asn_hold_next[7:0]     = in_byte;
          for (int i = 0; i < 4; i++) begin
            if (byte_position == 5'(7 + i)) value_hold_next[31 - 8*i -: 8] = in_byte;
            if (byte_position == 5'(11 + i)) begin
              prefix_shift_upper_next[63 - 8*i -: 8] = in_byte;
            end
          end
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (byte_position == 5'(i)) prefix_shift_upper_next[63 - 8*i -: 8] = in_byte;
            if (byte_position == 5'(8 + i)) prefix_shift_lower_next[63 - 8*i -: 8] = in_byte;
          end
        end
        byte_position_next = byte_position + 5'd1;
        bytes_left_next    = bytes_left - 5'd1;
        if (bytes_left == 5'd1) begin
          record_count_next = record_count + 13'd1;
          bundle.rec_v      = 1'b1;
          phase_next        = PH_LENGTH;
        end
      end
      default: phase_next = PH_LENGTH;
    endcase

    bundle.rec.kind  = KIND_RECORD;
    bundle.rec.upper = prefix_shift_upper_next;
    bundle.rec.lower = prefix_shift_lower_next;
    bundle.rec.bits  = current_length_next;
    bundle.rec.label = label_hold_next;
    bundle.rec.asn   = asn_hold_next;
    bundle.rec.value = value_hold_next;
    bundle.rec.count = record_count_next;
    bundle.rec.fin   = 1'b0;

    if (phase != PH_DROP) begin
      // truncated record: buffer ends inside a body
      if (!err && in_last && phase_next == PH_BODY) err = 1'b1;
      bundle.tail.count = record_count_next;
      bundle.tail.fin   = 1'b1;
      if (err) begin
        bundle.tail_v    = 1'b1;
        bundle.tail.kind = KIND_ERROR;
        if (in_last) begin
          phase_next        = PH_LENGTH;
          record_count_next = '0;
        end else begin
          phase_next = PH_DROP;
        end
      end else if (in_last) begin
        bundle.tail_v     = 1'b1;
        bundle.tail.kind  = KIND_DECODED;
        phase_next        = PH_LENGTH;
        record_count_next = '0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/nlri_dec_out.sv */
// ----------------------------------------------------------------------------
// nlri_dec_out
// Result register with one pending slot; sends a record and its end result
// one after the other.
// ----------------------------------------------------------------------------
`default_nettype none

module nlri_dec_out (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  nlri_dec_pkg::bundle_t  bundle,
  output logic                   slot_free,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output nlri_dec_pkg::res_t     res
);
  import nlri_dec_pkg::*;

  logic out_free;
  logic pend_v;
  res_t pend;

  assign out_free  = !m_tvalid || m_tready;
  assign slot_free = out_free && !pend_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend_v   <= 1'b0;
    end else if (out_free) begin
      if (pend_v) begin
        m_tvalid <= 1'b1;
        pend_v   <= 1'b0;
      end else if (push && (bundle.rec_v || bundle.tail_v)) begin
        m_tvalid <= 1'b1;
        pend_v   <= bundle.rec_v && bundle.tail_v;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_v) begin
        res <= pend;
      end else if (push && (bundle.rec_v || bundle.tail_v)) begin
        res  <= bundle.rec_v ? bundle.rec : bundle.tail;
        pend <= bundle.tail;
      end
    end
  end

endmodule

`default_nettype wire

/* design/nlri_prefix_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// nlri_prefix_stream_decoder_top
// BGP NLRI decoder: one byte in per cycle; results per prefix and buffer end.
// ----------------------------------------------------------------------------
// Bytes of a buffer enter on the s_ channel, s_tlast on the final byte.
// Results leave on the m_ channel: tuser carries the kind (record, buffer
// decoded, error), tlast marks the last result of a buffer.
// Configuration (address family, record limit) is written through
// cfg_we/cfg_index/cfg_data while no buffer is in flight.
// The input register holds each accepted byte; its decode is then written into
// the result register (or the pending slot), where the result becomes valid.
// Throughput: one byte per cycle while results can be stored; a byte that
// closes both a record and the buffer gives two results, and a following byte
// that gives a result waits until the second leaves the pending slot.
// Reset clears the decode state, the record count and both output slots;
// address family returns to IPv4 and the record limit to 4096.
// When the receiver stalls, the result register and the pending slot hold;
// bytes that give no result keep flowing until a result must be stored.
// ----------------------------------------------------------------------------
`default_nettype none

module nlri_prefix_stream_decoder_top (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,   // data_byte
  input  wire          s_tlast,   // last_byte
  output logic         m_tvalid,
  input  wire          m_tready,
  // prefix_upper, prefix_lower, prefix_bits, mpls_label, rd_asn, rd_value,
  // records_decoded, zero fill
  output logic [223:0] m_tdata,
  output logic [1:0]   m_tuser,   // result_kind
  output logic         m_tlast,   // final_result
  input  wire          cfg_we,
  input  wire          cfg_index,
  input  wire  [12:0]  cfg_data
);
  import nlri_dec_pkg::*;

  bundle_t bundle;
  res_t    res;
  logic    push;
  logic    slot_free;

  nlri_dec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_byte    (s_tdata),
    .s_last    (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .slot_free (slot_free),
    .push      (push),
    .bundle    (bundle)
  );

  nlri_dec_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .bundle    (bundle),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .res       (res)
  );

  assign m_tdata = {7'd0, res.count, res.value, res.asn, res.label, res.bits,
                    res.lower, res.upper};
  assign m_tuser = res.kind;
  assign m_tlast = res.fin;

endmodule

`default_nettype wire

/* dv/nlri_prefix_stream_decoder_top_test.sv */
// ----------------------------------------------------------------------------
// nlri_prefix_stream_decoder_top_test
// Self-checking bench for the NLRI prefix stream decoder.
// ----------------------------------------------------------------------------
// Bytes are pushed through the input stream with random gaps. A cycle-free
// decoder model computes the records, end results and errors that each
// accepted byte should produce. Results drained from the output stream,
// again with random stalls, are compared against that model in order.
// A short directed table covers the corner cases. A long random run
// follows, one address family and record limit per phase.
// ----------------------------------------------------------------------------

module nlri_prefix_stream_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nlri_dec_pkg::*;

  localparam logic [1:0] FAM_UNUSED = 2'd3;
  localparam int PREDICT    = -1;   // row checked against the decoder model
  localparam int IDLE_LIMIT = 400;
  localparam int SETTLE_CYC = 6;
  localparam int BYTE_GOAL  = 1100;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid;
  logic          s_tready;
  logic [7:0]    s_tdata;
  logic          s_tlast;
  logic          m_tvalid;
  logic          m_tready;
  logic [223:0]  m_tdata;
  logic [1:0]    m_tuser;
  logic          m_tlast;
  logic          cfg_we;
  logic          cfg_index;
  logic [12:0]   cfg_data;

  nlri_prefix_stream_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // decoder model: configuration copy and decode state
  logic [1:0]  fam_cfg = FAM_IPV4;
  logic [12:0] max_cfg = MAX_RECORDS_RESET;
  phase_t      ph = PH_LENGTH;
  logic [4:0]  left = '0;
  logic [7:0]  cur_len = '0;
  logic [4:0]  pos = '0;
  logic [63:0] upper = '0;
  logic [63:0] lower = '0;
  logic [19:0] label = '0;
  logic [15:0] asn = '0;
  logic [31:0] rd_val = '0;
  logic [12:0] rec_cnt = '0;
  logic [1:0]  fam_latch = FAM_IPV4;

  res_t decoded_q[$];
  int   yielded;        // results produced by the latest byte
  int   sent_bytes = 0; // every accepted byte, dropped ones included
  int   bad_results = 0;
  int   idle_cycles = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;

  task automatic emit(input kind_t k, input logic full, input logic fin);
    res_t r;
    r.kind  = k;
    r.upper = full ? upper : '0;
    r.lower = full ? lower : '0;
    r.bits  = full ? cur_len : '0;
    r.label = full ? label : '0;
    r.asn   = full ? asn : '0;
    r.value = full ? rd_val : '0;
    r.count = rec_cnt;
    r.fin   = fin;
    decoded_q.push_back(r);
    yielded++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic err;
    int   nb;
    int   p;
    err = 1'b0;
    yielded = 0;
    sent_bytes++;
    if (ph == PH_DROP) begin
      if (last) begin
        ph = PH_LENGTH;
        rec_cnt = '0;
      end
      return;
    end
    if (ph == PH_LENGTH) begin
      nb = (int'(b) + 7) / 8;
      fam_latch = fam_cfg;
      if (rec_cnt >= max_cfg) err = 1'b1;
      else if (fam_latch == FAM_IPV4 && b > V4_MAX_BITS) err = 1'b1;
      else if (fam_latch == FAM_IPV6 && b > V6_MAX_BITS) err = 1'b1;
      else if (fam_latch == FAM_VPNV4 && (b < VPN_MIN_BITS || b > VPN_MAX_BITS)) err = 1'b1;
      else if (fam_latch == FAM_UNUSED) err = 1'b1;
      if (!err) begin
        upper = '0;
        lower = '0;
        label = '0;
        asn = '0;
        rd_val = '0;
        pos = '0;
        cur_len = (fam_latch == FAM_VPNV4) ? b - VPN_MIN_BITS : b;
        left = nb[4:0];
        if (left == 0) begin
          rec_cnt = rec_cnt + 1'b1;
          emit(KIND_RECORD, 1'b1, 1'b0);
        end else begin
          ph = PH_BODY;
        end
      end
    end else begin
      p = int'(pos);
      if (fam_latch == FAM_VPNV4) begin
        // label (3 bytes), RD type (2, ignored), RD asn (2), RD value (4), prefix
        if (p == 0) label = {b, 12'h000};
        else if (p == 1) label = label | {8'h00, b, 4'h0};
        else if (p == 2) label = label | {16'h0000, b[7:4]};
        else if (p == 5) asn = {b, 8'h00};
        else if (p == 6) asn = asn | {8'h00, b};
        else if (p >= 7 && p <= 10) rd_val = rd_val | (32'(b) << ((10 - p) * 8));
        else if (p >= 11 && p <= 14) upper = upper | (64'(b) << ((18 - p) * 8));
      end else begin
        if (p < 8) upper = upper | (64'(b) << ((7 - p) * 8));
        else if (p < 16) lower = lower | (64'(b) << ((15 - p) * 8));
      end
      pos = pos + 1'b1;
      left = left - 1'b1;
      if (left == 0) begin
        rec_cnt = rec_cnt + 1'b1;
        emit(KIND_RECORD, 1'b1, 1'b0);
        ph = PH_LENGTH;
      end
    end
    // buffer ended inside a record body
    if (!err && last && ph == PH_BODY) err = 1'b1;
    if (err) begin
      emit(KIND_ERROR, 1'b0, 1'b1);
      ph = last ? PH_LENGTH : PH_DROP;
      if (last) rec_cnt = '0;
    end else if (last) begin
      emit(KIND_DECODED, 1'b0, 1'b1);
      ph = PH_LENGTH;
      rec_cnt = '0;
    end
  endtask

  function automatic res_t plain_result(input kind_t k, input logic [12:0] c);
    res_t r;
    r = '0;
    r.kind  = k;
    r.count = c;
    r.fin   = (k != KIND_RECORD);
    return r;
  endfunction

  function automatic void show_result(input string tag, input res_t r);
    $display("  %s kind=%0d upper=%h lower=%h bits=%0d label=%h asn=%h value=%h count=%0d fin=%b",
             tag, r.kind, r.upper, r.lower, r.bits, r.label, r.asn, r.value, r.count, r.fin);
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    decode_byte(b, last);
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    // a dropped byte may still be in flight
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ADDRESS_FAMILY) fam_cfg = val[1:0];
    else max_cfg = val;
  endtask

  function automatic int good_len();
    int r;
    r = $urandom_range(0, 9);
    case (fam_cfg)
      FAM_IPV4:  return (r == 0) ? 0 : (r == 1) ? 32 : $urandom_range(0, 32);
      FAM_IPV6:  return (r == 0) ? 0 : (r == 1) ? 128 :
                        (r == 2) ? $urandom_range(65, 128) : $urandom_range(0, 64);
      FAM_VPNV4: return (r == 0) ? 88 : (r == 1) ? 120 : $urandom_range(88, 120);
      default:   return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int bad_len();
    case (fam_cfg)
      FAM_IPV4:  return $urandom_range(33, 255);
      FAM_IPV6:  return $urandom_range(129, 255);
      FAM_VPNV4: return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 87) :
                                                    $urandom_range(121, 255);
      default:   return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_record(input int len, input logic ends_buffer);
    int nb;
    int j;
    nb = (len + 7) / 8;
    send_byte(8'(len), ends_buffer && nb == 0);
    for (j = 0; j < nb; j++) send_byte(8'($urandom), ends_buffer && j == nb - 1);
  endtask

  task automatic send_buffer();
    int style;
    int nrec;
    int len;
    int cut;
    int r;
    int j;
    style = $urandom_range(0, 9);
    if (style <= 6) begin
      nrec = $urandom_range(1, 5);
      for (r = 0; r < nrec; r++) send_record(good_len(), r == nrec - 1);
    end else if (style == 9) begin
      // noise
      cut = $urandom_range(1, 8);
      for (j = 0; j < cut; j++) send_byte(8'($urandom), j == cut - 1);
    end else begin
      nrec = $urandom_range(0, 2);
      for (r = 0; r < nrec; r++) send_record(good_len(), 1'b0);
      if (style == 7) begin
        // truncated record
        len = good_len();
        if (len == 0) len = 1;
        cut = $urandom_range(0, (len + 7) / 8 - 1);
        send_byte(8'(len), cut == 0);
        for (j = 0; j < cut; j++) send_byte(8'($urandom), j == cut - 1);
      end else begin
        // bad length, then bytes that get dropped
        cut = $urandom_range(0, 4);
        send_byte(8'(bad_len()), cut == 0);
        for (j = 0; j < cut; j++) send_byte(8'($urandom), j == cut - 1);
      end
    end
  endtask

  // ------------------------------------------------------- directed table
  typedef struct {
    logic [1:0]  fam;
    logic [12:0] maxr;
    logic [7:0]  data;
    logic        last;
    int          nexp;
    kind_t       k0;
    logic [12:0] c0;
    kind_t       k1;
    logic [12:0] c1;
  } probe_t;

  probe_t probes [25] = '{
    // zero-length prefix closing the buffer
    '{FAM_IPV4, 13'd4096, 8'd0,   1'b1, 2, KIND_RECORD, 13'd1, KIND_DECODED, 13'd1},
    // length above 32, rest of buffer dropped
    '{FAM_IPV4, 13'd4096, 8'd33,  1'b0, 1, KIND_ERROR, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_IPV4, 13'd4096, 8'hFF,  1'b0, 0, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_IPV4, 13'd4096, 8'h00,  1'b1, 0, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_IPV4, 13'd4096, 8'd8,   1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_IPV4, 13'd4096, 8'hFF,  1'b1, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    // truncated body
    '{FAM_IPV4, 13'd4096, 8'd24,  1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_IPV4, 13'd4096, 8'hA5,  1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_IPV4, 13'd4096, 8'h5A,  1'b1, 1, KIND_ERROR, 13'd0, KIND_RECORD, 13'd0},
    // record limit of zero
    '{FAM_IPV4, 13'd0,    8'd0,   1'b1, 1, KIND_ERROR, 13'd0, KIND_RECORD, 13'd0},
    // unused family selector
    '{FAM_UNUSED, 13'd4096, 8'd0, 1'b1, 1, KIND_ERROR, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_IPV6, 13'd4096, 8'd129, 1'b1, 1, KIND_ERROR, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'd87, 1'b1, 1, KIND_ERROR, 13'd0, KIND_RECORD, 13'd0},
    // shortest labelled prefix: label, RD, no prefix bytes
    '{FAM_VPNV4, 13'd4096, 8'd88, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'hFF, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'hFF, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'hF1, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'h00, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'h01, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'hFD, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'hE8, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'h00, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'h00, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'h30, 1'b0, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0},
    '{FAM_VPNV4, 13'd4096, 8'h39, 1'b1, PREDICT, KIND_RECORD, 13'd0, KIND_RECORD, 13'd0}
  };

  // ------------------------------------------------------------ main flow
  initial begin
    int          i;
    int          nbuf;
    int          pick;
    logic [1:0]  fam;
    logic [12:0] maxr;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_ADDRESS_FAMILY;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < 25; i++) begin
      if (probes[i].fam != fam_cfg || probes[i].maxr != max_cfg) begin
        settle();
        write_reg(REG_ADDRESS_FAMILY, 13'(probes[i].fam));
        write_reg(REG_MAX_RECORDS, probes[i].maxr);
      end
      send_byte(probes[i].data, probes[i].last);
      if (probes[i].nexp != PREDICT) begin
        // swap the modeled results for the hand-written ones
        repeat (yielded) void'(decoded_q.pop_back());
        if (probes[i].nexp > 0) decoded_q.push_back(plain_result(probes[i].k0, probes[i].c0));
        if (probes[i].nexp > 1) decoded_q.push_back(plain_result(probes[i].k1, probes[i].c1));
      end
    end

    while (sent_bytes < BYTE_GOAL) begin
      settle();
      pick = $urandom_range(0, 9);
      fam = (pick < 3) ? FAM_IPV4 : (pick < 6) ? FAM_IPV6 : (pick < 9) ? FAM_VPNV4 : FAM_UNUSED;
      pick = $urandom_range(0, 9);
      maxr = (pick < 4) ? 13'(pick) : (pick == 4) ? 13'($urandom_range(0, 4096)) : 13'd4096;
      write_reg(REG_ADDRESS_FAMILY, 13'(fam));
      write_reg(REG_MAX_RECORDS, maxr);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      nbuf = $urandom_range(3, 8);
      repeat (nbuf) send_buffer();
    end

    settle();
    if (bad_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // -------------------------------------------------------------- receiver
  initial begin
    int gap;
    m_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // ------------------------------------------------------- result checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind  = kind_t'(m_tuser);
      got.upper = m_tdata[63:0];
      got.lower = m_tdata[127:64];
      got.bits  = m_tdata[135:128];
      got.label = m_tdata[155:136];
      got.asn   = m_tdata[171:156];
      got.value = m_tdata[203:172];
      got.count = m_tdata[216:204];
      got.fin   = m_tlast;
      if (decoded_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("%0t: result with nothing pending", $realtime);
          show_result("act", got);
        end
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("%0t: result mismatch", $realtime);
            show_result("exp", want);
            show_result("act", got);
          end
        end
      end
    end
  end

  // stuck handshake watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

/* files.f */
design/nlri_dec_pkg.sv
design/nlri_dec_core.sv
design/nlri_dec_out.sv
design/nlri_prefix_stream_decoder_top.sv
dv/nlri_prefix_stream_decoder_top_test.sv
